// ===== rtl/core/linear_interp_downsampler_defines.svh =====
// Assertion macros shared by the rate reducer RTL.
// Included by the controller and datapath modules; no other dependencies.
`ifndef LINEAR_INTERP_DOWNSAMPLER_DEFINES_SVH
`define LINEAR_INTERP_DOWNSAMPLER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define LID_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define LID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lid_pkg.sv =====
// Shared types and constants of the linear interpolation rate reducer.
// Used by lid_ctrl, lid_dp, linear_interp_downsampler and the testbench; depends on nothing.
package lid_pkg;

	localparam int CHANNELS_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int RATE_W  = 16;
	localparam int PHASE_W = 17;
	localparam int CHAN_W  = 6;

	localparam logic [RATE_W-1:0] ORIG_RATE_RST = 16'd512;
	localparam logic [RATE_W-1:0] NEW_RATE_RST  = 16'd128;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIG_RATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_RATE  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} lid_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic prep;
		logic mul;
		logic div;
		logic finish;
	} lid_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic interp;
		logic div_done;
		logic out_stall;
	} lid_sts_t;

endpackage

// ===== rtl/core/lid_ctrl.sv =====
// Sequencing state machine of the rate reducer.
// Depends on lid_pkg and the assertion macros in linear_interp_downsampler_defines.svh.
`include "linear_interp_downsampler_defines.svh"

module lid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  lid_pkg::lid_sts_t sts,
	output lid_pkg::lid_cmd_t cmd
);

	lid_pkg::lid_state_t state_q;
	lid_pkg::lid_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lid_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lid_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nxt = lid_pkg::ST_PREP;
				end
			end
			lid_pkg::ST_PREP: begin
				state_nxt = sts.interp ? lid_pkg::ST_MUL : lid_pkg::ST_FIN;
			end
			lid_pkg::ST_MUL: begin
				state_nxt = lid_pkg::ST_DIV;
			end
			lid_pkg::ST_DIV: begin
				if (sts.div_done) begin
					state_nxt = lid_pkg::ST_FIN;
				end
			end
			lid_pkg::ST_FIN: begin
				// hold while the output register is still occupied
				if (!sts.out_stall) begin
					state_nxt = lid_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lid_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready  = (state_q == lid_pkg::ST_IDLE);
		cmd.take   = (state_q == lid_pkg::ST_IDLE) && req_valid;
		cmd.prep   = (state_q == lid_pkg::ST_PREP);
		cmd.mul    = (state_q == lid_pkg::ST_MUL);
		cmd.div    = (state_q == lid_pkg::ST_DIV);
		cmd.finish = (state_q == lid_pkg::ST_FIN) && !sts.out_stall;
	end

	`LID_ASSERT_NXT(a_take_prep, clk, arst_n, cmd.take, state_q == lid_pkg::ST_PREP, "request not followed by prep")
	`LID_ASSERT_NOW(a_no_drop, clk, arst_n, cmd.finish, !sts.out_stall, "result finished over a pending output")
	`LID_ASSERT_NXT(a_skip_div, clk, arst_n, cmd.prep && !sts.interp, state_q == lid_pkg::ST_FIN, "pass-through entered the divider")

endmodule

// ===== rtl/core/lid_dp.sv =====
// Datapath of the rate reducer: rate registers, sample history memory, phase,
// multiplier, 2-bit-per-cycle restoring divider and output register.
// Depends on lid_pkg and the assertion macros in linear_interp_downsampler_defines.svh.
`include "linear_interp_downsampler_defines.svh"

module lid_dp #(
	parameter int CHANNELS    = lid_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = lid_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lid_pkg::lid_cmd_t                   cmd,
	output lid_pkg::lid_sts_t                   sts,
	input  logic                                cfg_we,
	input  logic [lid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lid_pkg::RATE_W-1:0]          cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]       sample_in,
	input  logic [lid_pkg::CHAN_W-1:0]          chan_in,
	input  logic                                frame_end_in,
	input  logic                                restart,
	output logic signed [SAMPLE_BITS-1:0]       sample_out,
	output logic [lid_pkg::CHAN_W-1:0]          chan_out,
	output logic                                frame_end_out,
	output logic                                out_valid,
	input  logic                                out_ready
);

	localparam int AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DIFF_W    = SAMPLE_BITS + 1;
	localparam int PROD_W    = DIFF_W + lid_pkg::RATE_W;
	localparam int DIV_STEPS = (PROD_W + 1) / 2;
	localparam int DQ_W      = 2 * DIV_STEPS;
	localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);
	localparam logic [8:0] CH_LIM = 9'(CHANNELS);

	localparam int RW = lid_pkg::RATE_W;
	localparam int PW = lid_pkg::PHASE_W;

	// rate registers
	logic [RW-1:0] orig_q, new_q;
	logic [RW-1:0] o_eff, n_raw, n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orig_q <= lid_pkg::ORIG_RATE_RST;
			new_q  <= lid_pkg::NEW_RATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lid_pkg::CFG_ORIG_RATE: orig_q <= cfg_data;
				lid_pkg::CFG_NEW_RATE:  new_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		o_eff = (orig_q == '0) ? RW'(1) : orig_q;
		n_raw = (new_q == '0) ? RW'(1) : new_q;
		n_eff = (n_raw > o_eff) ? o_eff : n_raw;
	end

	// timing state
	logic [PW-1:0] phase_q, phase_nxt;
	logic          first_q;
	logic          first_now, phase_le_n;

	assign first_now  = first_q | restart;
	assign phase_le_n = (phase_q <= {1'b0, n_eff});

	// request capture
	logic [8:0]                    chan_ext;
	logic [AW-1:0]                 addr_in, addr_q;
	logic                          chan_ok_in, chan_ok_q;
	logic signed [SAMPLE_BITS-1:0] cur_q;
	logic [lid_pkg::CHAN_W-1:0]    chan_q;
	logic                          fend_q;
	logic [RW-1:0]                 d_q;
	logic                          first_item_q, interp_q, emit_q;

	assign chan_ext   = {3'b000, chan_in};
	assign addr_in    = chan_ext[AW-1:0];
	assign chan_ok_in = (chan_ext < CH_LIM);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cur_q     <= sample_in;
			chan_q    <= chan_in;
			addr_q    <= addr_in;
			chan_ok_q <= chan_ok_in;
			fend_q    <= frame_end_in;
			d_q       <= phase_q[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_item_q <= 1'b0;
			interp_q     <= 1'b0;
			emit_q       <= 1'b0;
		end else if (cmd.take) begin
			first_item_q <= first_now;
			interp_q     <= !first_now && phase_le_n;
			emit_q       <= first_now || phase_le_n;
		end
	end

	// sample history: memory plus per-entry valid bits
	logic [SAMPLE_BITS-1:0] mem_q [CHANNELS];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [CHANNELS-1:0]    vld_q;
	logic                   vld_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rd_q <= mem_q[addr_in];
		end
		if (cmd.prep && chan_ok_q) begin
			mem_q[addr_q] <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				vld_rd_q <= chan_ok_in && vld_q[addr_in];
			end
			if (cmd.prep && chan_ok_q) begin
				vld_q[addr_q] <= 1'b1;
			end
		end
	end

	// difference and its magnitude
	logic signed [SAMPLE_BITS-1:0] prev_val, prev_q;
	logic [DIFF_W-1:0]             diff, mag, mag_q;
	logic                          neg_q;

	always_comb begin
		prev_val = vld_rd_q ? $signed(rd_q) : '0;
		diff     = {cur_q[SAMPLE_BITS-1], cur_q} - {prev_val[SAMPLE_BITS-1], prev_val};
		mag      = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			prev_q <= prev_val;
			neg_q  <= diff[DIFF_W-1];
			mag_q  <= mag;
		end
	end

	// multiply then divide by n, two quotient bits per cycle
	logic [PROD_W-1:0] prod;
	logic [DQ_W-1:0]   dq_q;
	logic [RW-1:0]     rem_q, rem_a, rem_b;
	logic [RW:0]       r_a, r_b;
	logic              q_a, q_b;
	logic [CNT_W-1:0]  cnt_q;

	assign prod = PROD_W'(mag_q) * PROD_W'(d_q);

	always_comb begin
		r_a   = {rem_q, dq_q[DQ_W-1]};
		q_a   = (r_a >= {1'b0, n_eff});
		rem_a = q_a ? RW'(r_a - {1'b0, n_eff}) : r_a[RW-1:0];
		r_b   = {rem_a, dq_q[DQ_W-2]};
		q_b   = (r_b >= {1'b0, n_eff});
		rem_b = q_b ? RW'(r_b - {1'b0, n_eff}) : r_b[RW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			dq_q  <= DQ_W'(prod);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div) begin
			dq_q  <= {dq_q[DQ_W-3:0], q_a, q_b};
			rem_q <= rem_b;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// result: prev plus signed quotient, truncated toward zero
	logic [DIFF_W-1:0]             quo;
	logic [DIFF_W:0]               quo_ext, sq, interp_sum;
	logic signed [SAMPLE_BITS-1:0] res;

	always_comb begin
		quo        = dq_q[DIFF_W-1:0];
		quo_ext    = {1'b0, quo};
		sq         = neg_q ? (~quo_ext + (DIFF_W + 1)'(1)) : quo_ext;
		interp_sum = {{2{prev_q[SAMPLE_BITS-1]}}, prev_q} + sq;
		res        = first_item_q ? cur_q : $signed(interp_sum[SAMPLE_BITS-1:0]);
	end

	// phase advance at frame end
	always_comb begin
		priority if (first_item_q) begin
			phase_nxt = {1'b0, o_eff};
		end else if (interp_q) begin
			phase_nxt = PW'({1'b0, phase_q} + {2'b00, o_eff} - {2'b00, n_eff});
		end else begin
			phase_nxt = phase_q - {1'b0, n_eff};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			first_q <= 1'b1;
		end else if (cmd.finish) begin
			first_q <= fend_q ? 1'b0 : first_item_q;
			if (fend_q) begin
				phase_q <= phase_nxt;
			end
		end
	end

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic [lid_pkg::CHAN_W-1:0]    out_chan_q;
	logic                          out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish && emit_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && emit_q) begin
			out_sample_q <= res;
			out_chan_q   <= chan_q;
			out_last_q   <= fend_q;
		end
	end

	assign sample_out    = out_sample_q;
	assign chan_out      = out_chan_q;
	assign frame_end_out = out_last_q;
	assign out_valid     = out_valid_q;

	assign sts.interp    = interp_q;
	assign sts.div_done  = (cnt_q == LAST_STEP);
	assign sts.out_stall = emit_q && out_valid_q && !out_ready;

	`LID_ASSERT_NOW(a_quo_bound, clk, arst_n, cmd.finish && interp_q, quo <= mag_q, "quotient exceeds sample difference")
	`LID_ASSERT_NXT(a_phase_pos, clk, arst_n, cmd.finish && fend_q, phase_q != '0, "phase reached zero after a frame")

endmodule

// ===== rtl/core/linear_interp_downsampler.sv =====
// Linear interpolation rate reducer for interleaved multichannel sample frames:
// a request whose frame is passed through or dropped runs through the states IDLE,
// PREP and FIN; an interpolated one runs through IDLE, PREP, MUL, DIV and FIN, with
// DIV_STEPS = ceil((SAMPLE_BITS + 17) / 2) steps of the restoring divider in DIV,
// which retires two quotient bits per cycle. One request is in work at a time; an
// output register lets the next request enter while a result waits on m_axis_tready.
// History starts at zero through per-channel valid bits, so no clearing pass follows
// reset. cfg_ready is always high; write rates only while no request is in flight.
// Depends on lid_pkg, lid_ctrl and lid_dp.
module linear_interp_downsampler #(
	parameter int CHANNELS    = lid_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = lid_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lid_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lid_pkg::RATE_W-1:0]            cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// sample_in, chan_in, zero fill
	input  logic [((SAMPLE_BITS+lid_pkg::CHAN_W+7)/8)*8-1:0] s_axis_tdata,
	input  logic                                  s_axis_tlast,  // frame_end_in
	input  logic                                  s_axis_tuser,  // restart
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// sample_out, chan_out, zero fill
	output logic [((SAMPLE_BITS+lid_pkg::CHAN_W+7)/8)*8-1:0] m_axis_tdata,
	output logic                                  m_axis_tlast   // frame_end_out
);

	localparam int TDW = ((SAMPLE_BITS + lid_pkg::CHAN_W + 7) / 8) * 8;

	lid_pkg::lid_cmd_t cmd;
	lid_pkg::lid_sts_t sts;

	logic signed [SAMPLE_BITS-1:0] sample_in, sample_out;
	logic [lid_pkg::CHAN_W-1:0]    chan_in, chan_out;

	assign sample_in = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
	assign chan_in   = s_axis_tdata[SAMPLE_BITS+lid_pkg::CHAN_W-1:SAMPLE_BITS];
	assign m_axis_tdata = TDW'({chan_out, sample_out});
	assign cfg_ready = 1'b1;

	lid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lid_dp #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_in     (sample_in),
		.chan_in       (chan_in),
		.frame_end_in  (s_axis_tlast),
		.restart       (s_axis_tuser),
		.sample_out    (sample_out),
		.chan_out      (chan_out),
		.frame_end_out (m_axis_tlast),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready)
	);

endmodule

// ===== dv/tb_linear_interp_downsampler.sv =====
// Self-checking testbench for the linear interpolation rate reducer.
// Drives sample requests and rate writes, predicts every output sample.
// Depends on lid_pkg and linear_interp_downsampler.
`timescale 1ns / 1ps

module tb_linear_interp_downsampler;
	import lid_pkg::*;

	localparam int SW            = SAMPLE_BITS_DEF;
	localparam int DATA_W        = ((SW + CHAN_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS  = 830;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 40;
	localparam int DIR_N         = 20;

	typedef struct packed {
		logic [SW-1:0]     sample;
		logic [CHAN_W-1:0] chan;
		logic              last;
	} out_sample_t;

	typedef struct packed {
		logic [SW-1:0]     sample;
		logic [CHAN_W-1:0] chan;
		logic              fend;
		logic              rst;
		logic              known;
		logic [SW-1:0]     typed;
	} dir_row_t;

	// rates after reset: 512 in, 128 out, so one output every fourth frame
	dir_row_t dir_tab [DIR_N] = '{
		'{24'h7FFFFF, 6'd0,  1'b0, 1'b0, 1'b1, 24'h7FFFFF},
		'{24'h800000, 6'd63, 1'b1, 1'b0, 1'b1, 24'h800000},
		'{24'h000000, 6'd0,  1'b0, 1'b0, 1'b0, 24'h000000},
		'{24'hFFFFFF, 6'd63, 1'b1, 1'b0, 1'b0, 24'h000000},
		'{24'h123456, 6'd0,  1'b0, 1'b0, 1'b0, 24'h000000},
		'{24'hEDCBA9, 6'd63, 1'b1, 1'b0, 1'b0, 24'h000000},
		'{24'h400000, 6'd0,  1'b0, 1'b0, 1'b0, 24'h000000},
		'{24'h3FFFFF, 6'd63, 1'b1, 1'b0, 1'b0, 24'h000000},
		'{24'h800000, 6'd0,  1'b0, 1'b0, 1'b0, 24'h000000},
		'{24'h7FFFFF, 6'd63, 1'b1, 1'b0, 1'b0, 24'h000000},
		// restart in the middle of a frame
		'{24'h000100, 6'd0,  1'b0, 1'b0, 1'b0, 24'h000000},
		'{24'hABCDEF, 6'd1,  1'b0, 1'b1, 1'b1, 24'hABCDEF},
		'{24'h0F0F0F, 6'd63, 1'b1, 1'b0, 1'b1, 24'h0F0F0F},
		// frame end on every request
		'{24'h111111, 6'd0,  1'b1, 1'b0, 1'b0, 24'h000000},
		'{24'h222222, 6'd0,  1'b1, 1'b0, 1'b0, 24'h000000},
		'{24'h333333, 6'd0,  1'b1, 1'b0, 1'b0, 24'h000000},
		'{24'h7FFFFF, 6'd0,  1'b1, 1'b0, 1'b0, 24'h000000},
		// frame end missing
		'{24'h555555, 6'd5,  1'b0, 1'b0, 1'b0, 24'h000000},
		'{24'hAAAAAA, 6'd6,  1'b0, 1'b0, 1'b0, 24'h000000},
		'{24'h000001, 6'd0,  1'b1, 1'b1, 1'b1, 24'h000001}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RATE_W-1:0]    cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [DATA_W-1:0]    s_axis_tdata;   // sample_in, chan_in, zero fill
	logic                 s_axis_tlast;   // frame_end_in
	logic                 s_axis_tuser;   // restart
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [DATA_W-1:0]    m_axis_tdata;   // sample_out, chan_out, zero fill
	logic                 m_axis_tlast;   // frame_end_out

	// predictor state
	logic [RATE_W-1:0]    rate_in;
	logic [RATE_W-1:0]    rate_out;
	logic signed [SW-1:0] last_sample [CHANNELS_DEF];
	logic [PHASE_W-1:0]   out_phase;
	bit                   at_time_zero;

	out_sample_t due_q [$];
	int          errors;
	int          items_sent;
	bit          steady;

	linear_interp_downsampler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	task automatic predict_resample(input logic [SW-1:0] sample, input logic [CHAN_W-1:0] chan,
			input logic fend, input logic rst, output bit emits, output logic [SW-1:0] value);
		logic [PHASE_W-1:0] o;
		logic [PHASE_W-1:0] n;
		longint cur;
		longint prv;
		longint q;
		o = (rate_in == 0) ? PHASE_W'(1) : PHASE_W'(rate_in);
		n = (rate_out == 0) ? PHASE_W'(1) : PHASE_W'(rate_out);
		if (n > o)
			n = o;
		cur = $signed(sample);
		prv = last_sample[chan];
		if (rst)
			at_time_zero = 1'b1;
		emits = 1'b1;
		value = sample;
		if (!at_time_zero) begin
			if (out_phase <= n) begin
				q = prv + ((cur - prv) * longint'(out_phase)) / longint'(n);
				value = q[SW-1:0];
			end else begin
				emits = 1'b0;
			end
		end
		last_sample[chan] = sample;
		// advance the output instant once per frame
		if (fend) begin
			if (at_time_zero)
				out_phase = o;
			else if (out_phase <= n)
				out_phase = out_phase + o - n;
			else
				out_phase = out_phase - n;
			at_time_zero = 1'b0;
		end
	endtask

	function automatic logic [SW-1:0] draw_sample();
		case ($urandom_range(0, 11))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return 24'hFFFFFF;
			default: return SW'($urandom());
		endcase
	endfunction

	task automatic send_sample(input logic [SW-1:0] sample, input logic [CHAN_W-1:0] chan,
			input logic fend, input logic rst, input logic known, input logic [SW-1:0] typed);
		int gap;
		bit emits;
		logic [SW-1:0] value;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= DATA_W'({chan, sample});
		s_axis_tlast  <= fend;
		s_axis_tuser  <= rst;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		predict_resample(sample, chan, fend, rst, emits, value);
		if (known)
			due_q.push_back('{typed, chan, fend});
		else if (emits)
			due_q.push_back('{value, chan, fend});
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (due_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_rates(input logic [RATE_W-1:0] o, input logic [RATE_W-1:0] n);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ORIG_RATE;
		cfg_data  <= o;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_NEW_RATE;
		cfg_data  <= n;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		rate_in  = o;
		rate_out = n;
	endtask

	// mostly well-formed frames with channels in order, some broken ones
	task automatic send_frame(input bit force_restart);
		int kind;
		int width;
		int mid;
		logic rst;
		kind  = force_restart ? 0 : $urandom_range(0, 99);
		width = ($urandom_range(0, 9) == 0) ? $urandom_range(1, CHANNELS_DEF) : $urandom_range(1, 6);
		mid   = ($urandom_range(0, 24) == 0) ? int'($urandom_range(0, width - 1)) : -1;
		for (int i = 0; i < width; i++) begin
			if (kind < 85) begin
				rst = (i == 0 && (force_restart || $urandom_range(0, 29) == 0)) || i == mid;
				send_sample(draw_sample(), CHAN_W'(i), i == width - 1, rst, 1'b0, '0);
			end else if (kind < 92) begin
				send_sample(draw_sample(), CHAN_W'($urandom()), 1'b1,
					$urandom_range(0, 19) == 0, 1'b0, '0);
			end else begin
				send_sample(draw_sample(), CHAN_W'($urandom()), 1'($urandom_range(0, 1)),
					$urandom_range(0, 9) == 0, 1'b0, '0);
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		out_sample_t got;
		out_sample_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[SW-1:0], m_axis_tdata[SW+CHAN_W-1:SW], m_axis_tlast};
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual sample %h chan %0d last %b",
					$time, got.sample, got.chan, got.last);
			end else begin
				want = due_q.pop_front();
				if (got.sample !== want.sample || got.chan !== want.chan || got.last !== want.last) begin
					errors++;
					$display("%0t: expected sample %h chan %0d last %b, actual sample %h chan %0d last %b",
						$time, want.sample, want.chan, want.last, got.sample, got.chan, got.last);
				end
			end
		end
	end

	initial begin : sink
		int stall;
		m_axis_tready = 1'b0;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("** linear_interp_downsampler: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int phase_no;
		int start;
		int frames;
		logic [RATE_W-1:0] o;
		logic [RATE_W-1:0] n;
		int oe;
		int ne;
		bit kick;
		bit sparse;
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_ORIG_RATE;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		s_axis_tuser  = 1'b0;
		steady        = 1'b0;
		errors        = 0;
		items_sent    = 0;
		rate_in       = ORIG_RATE_RST;
		rate_out      = NEW_RATE_RST;
		out_phase     = '0;
		at_time_zero  = 1'b1;
		foreach (last_sample[i])
			last_sample[i] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_sample(dir_tab[i].sample, dir_tab[i].chan, dir_tab[i].fend, dir_tab[i].rst,
				dir_tab[i].known, dir_tab[i].typed);

		phase_no = 0;
		kick = 1'b1;
		while (items_sent < DIR_N + RANDOM_ITEMS) begin
			drain_results();
			repeat (SETTLE_CYCLES) @(posedge clk);
			case (phase_no)
				0: begin o = 16'd0;     n = 16'd0;     end
				1: begin o = 16'd65535; n = 16'd65535; end
				2: begin o = 16'd1;     n = 16'd65535; end
				3: begin o = 16'd65535; n = 16'd1;     end
				4: begin o = 16'd3;     n = 16'd2;     end
				default: begin
					case ($urandom_range(0, 9))
						0: begin
							o = RATE_W'($urandom());
							n = RATE_W'($urandom());
						end
						1: begin
							o = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
							n = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
						end
						default: begin
							o = RATE_W'($urandom_range(1, 600));
							n = RATE_W'($urandom_range((o + 4) / 5, o));
						end
					endcase
				end
			endcase
			write_rates(o, n);
			oe = (o == 0) ? 1 : o;
			ne = (n == 0) ? 1 : n;
			if (ne > oe)
				ne = oe;
			sparse = (oe / ne) > 8;
			steady = ($urandom_range(0, 3) == 0);
			start = items_sent;
			frames = 0;
			while (items_sent - start < PHASE_ITEMS) begin
				send_frame(kick && frames == 0);
				frames++;
				// hold the sender until every output has drained
				if (phase_no % 5 == 2 && frames == 2)
					drain_results();
			end
			// restart after a sparse setting so the phase does not crawl
			kick = sparse;
			phase_no++;
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && due_q.size() == 0)
			$display("** linear_interp_downsampler: PASSED **");
		else
			$display("** linear_interp_downsampler: FAILED **");
		$finish;
	end

endmodule

// ===== linear_interp_downsampler.f =====
+incdir+rtl/core
rtl/core/lid_pkg.sv
rtl/core/lid_ctrl.sv
rtl/core/lid_dp.sv
rtl/core/linear_interp_downsampler.sv
dv/tb_linear_interp_downsampler.sv
